FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types, codes and defaults for the scheduler and its queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // Default number of ready queue cells
  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned REM_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_DW   = 32;
  localparam int unsigned OUT_DW  = 32;

  // Opcodes carried in the input tuser
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Status codes carried in the output tuser
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_RAN      = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDLE     = 2'd3;

  // One task as held in a queue cell or the running slot
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [REM_W-1:0]  rem;
  } task_t;

  // Queue operation broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REINS,
    S_RUN
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/pps_cell.sv
// ----------------------------------------------------------------------------
// Ready queue cell
// One slot of the sorted ready queue. Takes part in a sorted insert by
// comparing against its own and its left neighbor's priority, and moves
// its right neighbor's task in on a head removal.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_cell (
  input  wire                       clk_i,
  input  wire pps_pkg::cell_ctrl_t  ctrl_i,
  input  wire                       occ_i,       // this slot holds a task
  input  wire                       prev_occ_i,  // left neighbor holds a task
  input  wire pps_pkg::task_t       prev_i,
  input  wire pps_pkg::task_t       next_i,
  input  wire pps_pkg::task_t       new_i,
  output pps_pkg::task_t            ent_o
);

  pps_pkg::task_t ent_q, ent_d;
  logic           prev_later;
  logic           self_later;

  // Decide whether the new task lands here or pushes from the left
  assign prev_later = prev_occ_i && (prev_i.prio > new_i.prio);
  assign self_later = !occ_i || (ent_q.prio > new_i.prio);

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.shift) begin
      ent_d = next_i;
    end else if (ctrl_i.insert) begin
      if (prev_later) begin
        ent_d = prev_i;
      end else if (self_later) begin
        ent_d = new_i;
      end
    end
  end

  // Hold the slot contents
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

FILE: rtl/core/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Ready queue as a row of sorted cells plus one running slot. Arrivals are
// inserted in priority order (first come first served on ties); ticks
// dispatch, preempt and run the current task for one unit.
// ----------------------------------------------------------------------------
// Channel   Dir  tuser             tdata
// s_axis    in   [0] opcode        [7:0] task_id [15:8] task_priority
//                                  [31:16] burst_length
// m_axis    out  [1:0] status      [7:0] running_id [8] completed
//                                  [9] preempted [25:10] time_left
//
// An arrive word passes EXEC, which registers its result; a tick word passes EXEC
// and RUN, with REINS between them when it preempts (head removal in EXEC and
// reinsertion in REINS, each through the cell row). One word is in flight at a
// time; the next is taken once the FSM is back in idle and the output register
// is free or drained. Reset clears the queue count, the running slot and the
// FSM; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int unsigned QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [pps_pkg::IN_DW-1:0]    s_axis_tdata,  // task_id, task_priority, burst_length
  input  wire                          s_axis_tuser,  // opcode
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [pps_pkg::OUT_DW-1:0]   m_axis_tdata,  // running_id, completed, preempted,
                                                      // time_left, zero pad
  output logic [pps_pkg::STAT_W-1:0]   m_axis_tuser   // status
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pps_pkg::state_e     state_q, state_d;
  pps_pkg::cell_ctrl_t ctrl;
  pps_pkg::task_t      ent [QUEUE_DEPTH];
  pps_pkg::task_t      itm_q;
  pps_pkg::task_t      cur_q;
  pps_pkg::task_t      in_task;
  logic [CNT_W-1:0]    count_q;
  logic [QUEUE_DEPTH-1:0] occ;
  logic                op_q;
  logic                pre_q;
  logic                cur_valid_q;
  logic                out_valid_q;
  logic                accept;
  logic                full;
  logic                nonempty;
  logic                preempt;
  logic                run_done;
  logic [pps_pkg::REM_W-1:0] rem_dec;

  assign in_task.id   = s_axis_tdata[7:0];
  assign in_task.prio = s_axis_tdata[15:8];
  assign in_task.rem  = s_axis_tdata[31:16];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count_q != '0);
  assign preempt  = cur_valid_q && nonempty && (ent[0].prio < cur_q.prio);

  // Saturating decrement of the running task
  assign rem_dec  = (cur_q.rem != '0) ? cur_q.rem - 1'b1 : cur_q.rem;
  assign run_done = (rem_dec == '0);

  // Build the row of queue cells
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    assign occ[k] = (count_q > CNT_W'(k));
    if (k == 0) begin : g_first
      pps_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (occ[k]),
        .prev_occ_i (1'b0),
        .prev_i     (itm_q),
        .next_i     ((QUEUE_DEPTH > 1) ? ent[(QUEUE_DEPTH > 1) ? 1 : 0] : ent[0]),
        .new_i      (itm_q),
        .ent_o      (ent[k])
      );
    end else if (k == QUEUE_DEPTH - 1) begin : g_last
      pps_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (occ[k]),
        .prev_occ_i (occ[k-1]),
        .prev_i     (ent[k-1]),
        .next_i     (ent[k]),
        .new_i      (itm_q),
        .ent_o      (ent[k])
      );
    end else begin : g_mid
      pps_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (occ[k]),
        .prev_occ_i (occ[k-1]),
        .prev_i     (ent[k-1]),
        .next_i     (ent[k+1]),
        .new_i      (itm_q),
        .ent_o      (ent[k])
      );
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pps_pkg::S_IDLE: begin
        if (accept) begin
          state_d = pps_pkg::S_EXEC;
        end
      end
      pps_pkg::S_EXEC: begin
        if (op_q == pps_pkg::OP_ARRIVE) begin
          state_d = pps_pkg::S_IDLE;
        end else if (preempt) begin
          state_d = pps_pkg::S_REINS;
        end else begin
          state_d = pps_pkg::S_RUN;
        end
      end
      pps_pkg::S_REINS: state_d = pps_pkg::S_RUN;
      pps_pkg::S_RUN:   state_d = pps_pkg::S_IDLE;
      default:          state_d = pps_pkg::S_IDLE;
    endcase
  end

  // State outputs: handshake and cell row control
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    case (state_q)
      pps_pkg::S_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
      end
      pps_pkg::S_EXEC: begin
        if (op_q == pps_pkg::OP_ARRIVE) begin
          ctrl.insert = !full;
        end else begin
          ctrl.shift = nonempty && (!cur_valid_q || preempt);
        end
      end
      pps_pkg::S_REINS: begin
        ctrl.insert = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pps_pkg::S_IDLE;
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      pre_q       <= 1'b0;
      op_q        <= pps_pkg::OP_ARRIVE;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q  <= s_axis_tuser;
        pre_q <= 1'b0;
      end
      // Drop the result once taken
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.shift) begin
        count_q     <= count_q - 1'b1;
        cur_valid_q <= 1'b1;
        pre_q       <= cur_valid_q;
      end else if (ctrl.insert) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == pps_pkg::S_EXEC && op_q == pps_pkg::OP_ARRIVE) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == pps_pkg::S_RUN) begin
        out_valid_q <= 1'b1;
        if (cur_valid_q && run_done) begin
          cur_valid_q <= 1'b0;
        end
      end
    end
  end

  // Task payload and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      itm_q <= in_task;
    end
    if (ctrl.shift) begin
      cur_q <= ent[0];
      // Park the preempted task for reinsertion
      itm_q <= cur_q;
    end
    if (state_q == pps_pkg::S_EXEC && op_q == pps_pkg::OP_ARRIVE) begin
      m_axis_tuser <= full ? pps_pkg::ST_REJECTED : pps_pkg::ST_ACCEPTED;
      m_axis_tdata <= '0;
    end
    if (state_q == pps_pkg::S_RUN) begin
      if (cur_valid_q) begin
        cur_q.rem    <= rem_dec;
        m_axis_tuser <= pps_pkg::ST_RAN;
        m_axis_tdata <= {6'd0, rem_dec, pre_q, run_done, cur_q.id};
      end else begin
        m_axis_tuser <= pps_pkg::ST_IDLE;
        m_axis_tdata <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire
